[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// ante in a cycle implies cons in the same cycle
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// ante in a cycle implies cons in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

// cond never holds
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`define ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

[sv/dad_pkg.sv]
// ----------------------------------------------------------------------------
// dad_pkg
// Types and constants shared by the ADPCM decoder modules.
// ----------------------------------------------------------------------------
package dad_pkg;

   localparam int FRAME_BYTES = 8;
   localparam int POS_W       = $clog2(FRAME_BYTES);
   localparam int CSR_COUNT   = 4;
   localparam int CSR_IDX_W   = $clog2(CSR_COUNT);
   localparam int CSR_DATA_W  = 64;
   localparam int SCALE_BASE  = 11;
   localparam int DIV_SHIFT   = 11;
   localparam int DIV_BIAS    = (1 << DIV_SHIFT) - 1;
   localparam int PCM_MAX     = 32767;
   localparam int PCM_MIN     = -32768;

   typedef struct packed {
      logic [7:0]         code_byte;
      logic               block_begin;
      logic signed [15:0] start_hist_a;
      logic signed [15:0] start_hist_b;
   } req_word_type;

   typedef struct packed {
      logic signed [15:0] pcm_sample;
      logic               run_last;
   } rsp_word_type;

   typedef enum logic {
      CMD_LOAD,
      CMD_DECODE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic [7:0]         code_byte;
      logic [3:0]         scale_shift;
      logic signed [15:0] coef_a;
      logic signed [15:0] coef_b;
      logic signed [15:0] hist_a;
      logic signed [15:0] hist_b;
   } cmd_word_type;

endpackage

[sv/dsp_adpcm_decoder_core.sv]
// ----------------------------------------------------------------------------
// dsp_adpcm_decoder_core
// DSP-ADPCM decoder: 8-byte frames of header plus seven data bytes, two PCM
// samples per data byte.
// Each data byte's samples pass the command queue, the multiply stage, the
// accumulate/clamp stage and the result queue; the history loop takes each
// sample through both engine stages before it starts the next. Plain headers
// take no engine time; a block-begin header only loads history. Synchronous
// reset clears queues, frame position and coefficients.
// ----------------------------------------------------------------------------
module dsp_adpcm_decoder_core #(
   parameter int CMD_DEPTH = 2,
   parameter int RSP_DEPTH = 2
) (
   input  logic                           clock,
   input  logic                           reset,
   // configuration
   input  logic                           csr_we,
   input  logic [dad_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dad_pkg::CSR_DATA_W-1:0] csr_wdata,
   // compressed byte words in
   input  logic                           req_push,
   input  dad_pkg::req_word_type          req_word,
   output logic                           req_full,
   // PCM sample words out
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output dad_pkg::rsp_word_type          rsp_word
);
   import dad_pkg::*;

   // front to back command queue
   logic         cmd_push, cmd_full, cmd_empty, cmd_pop;
   cmd_word_type cmd_wr_word, cmd_rd_word;

   // back to result queue
   logic         out_push, out_full;
   rsp_word_type out_word;

   // classify bytes, track the frame, look up coefficients
   dad_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_push  (req_push),
      .req_word  (req_word),
      .req_full  (req_full),
      .cmd_push  (cmd_push),
      .cmd_word  (cmd_wr_word),
      .cmd_full  (cmd_full)
   );

   // hold decoded commands so the front keeps taking bytes while the engine works
   dad_fifo #(
      .WIDTH ($bits(cmd_word_type)),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .wdata (cmd_wr_word),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .rdata (cmd_rd_word),
      .empty (cmd_empty)
   );

   // run the predictor, finishing one sample before it starts the next
   dad_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_word  (cmd_rd_word),
      .cmd_pop   (cmd_pop),
      .out_push  (out_push),
      .out_word  (out_word),
      .out_full  (out_full)
   );

   // decouple the sink: finished samples wait here while work goes on
   dad_fifo #(
      .WIDTH ($bits(rsp_word_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_word),
      .full  (out_full),
      .pop   (rsp_pop),
      .rdata (rsp_word),
      .empty (rsp_empty)
   );

endmodule

[sv/dad_fifo.sv]
// ----------------------------------------------------------------------------
// dad_fifo
// Small register-based queue with registered storage and one read port.
// ----------------------------------------------------------------------------
module dad_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rdata   = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

[sv/dad_front.sv]
// ----------------------------------------------------------------------------
// dad_front
// Frame tracking, header parsing and coefficient lookup; emits commands.
// ----------------------------------------------------------------------------
module dad_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [dad_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [dad_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic                                  req_push,
   input  dad_pkg::req_word_type                 req_word,
   output logic                                  req_full,
   output logic                                  cmd_push,
   output dad_pkg::cmd_word_type                 cmd_word,
   input  logic                                  cmd_full
);
   import dad_pkg::*;

   logic [CSR_DATA_W-1:0] coef_bank_ff [CSR_COUNT];
   logic [POS_W-1:0]      frame_pos_ff, frame_pos_in;
   logic [3:0]            scale_ff, scale_in;
   logic [2:0]            pair_ff, pair_in;
   logic                  accept, is_header;
   logic [CSR_DATA_W-1:0] bank;
   logic [31:0]           pair_bits;

   assign req_full  = cmd_full;
   assign accept    = req_push && !cmd_full;
   assign is_header = req_word.block_begin || (frame_pos_ff == '0);

   // pick the coefficient pair named by the last header
   assign bank      = coef_bank_ff[pair_ff[2:1]];
   assign pair_bits = pair_ff[0] ? bank[63:32] : bank[31:0];

   assign cmd_push = accept && (req_word.block_begin || !is_header);

   always_comb begin
      cmd_word.kind        = req_word.block_begin ? CMD_LOAD : CMD_DECODE;
      cmd_word.code_byte   = req_word.code_byte;
      cmd_word.scale_shift = scale_ff;
      cmd_word.coef_a      = $signed(pair_bits[15:0]);
      cmd_word.coef_b      = $signed(pair_bits[31:16]);
      cmd_word.hist_a      = req_word.start_hist_a;
      cmd_word.hist_b      = req_word.start_hist_b;
   end

   always_comb begin
      frame_pos_in = frame_pos_ff;
      scale_in     = scale_ff;
      pair_in      = pair_ff;
      if (accept) begin
         if (is_header) begin
            scale_in     = req_word.code_byte[3:0];
            pair_in      = req_word.code_byte[6:4];
            frame_pos_in = POS_W'(1);
         end else begin
            frame_pos_in = (frame_pos_ff == POS_W'(FRAME_BYTES - 1)) ? '0
                                                                     : frame_pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_pos_ff <= '0;
         scale_ff     <= '0;
         pair_ff      <= '0;
         for (int i = 0; i < CSR_COUNT; i++) begin
            coef_bank_ff[i] <= '0;
         end
      end else begin
         frame_pos_ff <= frame_pos_in;
         scale_ff     <= scale_in;
         pair_ff      <= pair_in;
         if (csr_we) begin
            coef_bank_ff[csr_index] <= csr_wdata;
         end
      end
   end

endmodule

[sv/dad_back.sv]
// ----------------------------------------------------------------------------
// dad_back
// Sample engine: multiply history by coefficients, then accumulate and clamp.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dad_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_empty,
   input  dad_pkg::cmd_word_type cmd_word,
   output logic                  cmd_pop,
   output logic                  out_push,
   output dad_pkg::rsp_word_type out_word,
   input  logic                  out_full
);
   import dad_pkg::*;

   typedef enum logic {
      S_MUL,
      S_ADD
   } state_type;

   state_type          state_ff, state_in;
   logic               half_ff, half_in;
   logic signed [15:0] hist_newer_ff, hist_newer_in;
   logic signed [15:0] hist_older_ff, hist_older_in;
   logic signed [31:0] prod_a_ff, prod_a_in;
   logic signed [31:0] prod_b_ff, prod_b_in;
   logic signed [30:0] term_ff, term_in;
   logic [3:0]         nib;
   logic [4:0]         shamt;
   logic signed [33:0] sum, biased, quot;
   logic signed [15:0] sample;
   logic               take_load, take_decode;

   assign take_load   = (state_ff == S_MUL) && !cmd_empty && (cmd_word.kind == CMD_LOAD);
   assign take_decode = (state_ff == S_MUL) && !cmd_empty && (cmd_word.kind == CMD_DECODE);

   // high nibble first
   assign nib   = half_ff ? cmd_word.code_byte[3:0] : cmd_word.code_byte[7:4];
   assign shamt = {1'b0, cmd_word.scale_shift} + 5'(SCALE_BASE);

   assign prod_a_in = cmd_word.coef_a * hist_newer_ff;
   assign prod_b_in = cmd_word.coef_b * hist_older_ff;
   assign term_in   = 31'($signed(nib)) <<< shamt;

   // divide by 2048 toward zero, then clamp
   assign sum    = 34'(prod_a_ff) + 34'(prod_b_ff) + 34'(term_ff);
   assign biased = sum[33] ? sum + 34'(DIV_BIAS) : sum;
   assign quot   = biased >>> DIV_SHIFT;

   always_comb begin
      if (quot > 34'(PCM_MAX)) begin
         sample = 16'(PCM_MAX);
      end else if (quot < 34'(PCM_MIN)) begin
         sample = 16'(PCM_MIN);
      end else begin
         sample = quot[15:0];
      end
   end

   assign out_push            = (state_ff == S_ADD) && !out_full;
   assign out_word.pcm_sample = sample;
   assign out_word.run_last   = half_ff;
   assign cmd_pop             = take_load || (out_push && half_ff);

   always_comb begin
      state_in      = state_ff;
      half_in       = half_ff;
      hist_newer_in = hist_newer_ff;
      hist_older_in = hist_older_ff;
      case (state_ff)
         S_MUL: begin
            if (take_load) begin
               hist_newer_in = cmd_word.hist_a;
               hist_older_in = cmd_word.hist_b;
            end else if (take_decode) begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            if (out_push) begin
               hist_older_in = hist_newer_ff;
               hist_newer_in = sample;
               half_in       = !half_ff;
               state_in      = S_MUL;
            end
         end
         default: begin
            state_in = S_MUL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_MUL;
         half_ff       <= 1'b0;
         hist_newer_ff <= '0;
         hist_older_ff <= '0;
      end else begin
         state_ff      <= state_in;
         half_ff       <= half_in;
         hist_newer_ff <= hist_newer_in;
         hist_older_ff <= hist_older_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_decode) begin
         prod_a_ff <= prod_a_in;
         prod_b_ff <= prod_b_in;
         term_ff   <= term_in;
      end
   end

   `ASSERT_IMPL(a_push_in_add, clock, reset, out_push, state_ff == S_ADD)
   `ASSERT_NEVER(a_push_when_full, clock, reset, out_push && out_full)
   `ASSERT_NEXT(a_low_done_back_to_mul, clock, reset, out_push && half_ff, (state_ff == S_MUL) && !half_ff)
   `ASSERT_IMPL(a_pop_reason, clock, reset, cmd_pop, take_load || (out_push && half_ff && (cmd_word.kind == CMD_DECODE)))

endmodule
